// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define AR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define AR_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// ----- design/aesrnd_pkg.sv -----
// types, S-box table and GF(2^8) helper for the AES round datapath
// no dependencies
package aesrnd_pkg;

	localparam int unsigned NumCols = 4;
	localparam int unsigned NumRows = 4;

	typedef logic [7:0] byte_t;
	typedef byte_t [NumRows-1:0] column_t;

	// pipeline load enables from the top-level control
	typedef struct packed {
		logic load_s1;
		logic load_s2;
	} pipe_ctl_t;

	localparam byte_t RedPoly = 8'h1B;

	localparam byte_t SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,
		8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
		8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,
		8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,
		8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
		8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,
		8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,
		8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
		8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,
		8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,
		8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
		8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,
		8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,
		8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
		8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,
		8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,
		8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// multiply by x in GF(2^8), reduce by x^8+x^4+x^3+x+1
	function automatic byte_t gf_double(input byte_t v);
		byte_t d;
		d = {v[6:0], 1'b0};
		if (v[7]) begin
			d = d ^ RedPoly;
		end
		return d;
	endfunction

endpackage

// ----- design/aesrnd_if.sv -----
// valid/ready channel interfaces for the AES round block
// no dependencies
interface aesrnd_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] state_hi;
	logic [63:0] state_lo;

	modport source (output valid, output state_hi, output state_lo, input ready);
	modport sink (input valid, input state_hi, input state_lo, output ready);
endinterface

interface aesrnd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_hi;
	logic [63:0] result_lo;

	modport source (output valid, output result_hi, output result_lo, input ready);
	modport sink (input valid, input result_hi, input result_lo, output ready);
endinterface

// ----- design/aes_round_without_key_add_unit.sv -----
// AES round without key addition: SubBytes, ShiftRows, MixColumns
// Channels: blk_in carries the state as state_hi/state_lo, byte 0 in bits
// 63:56 of state_hi, column-major; blk_out carries result_hi/result_lo in
// the same layout. A transaction completes on a clock edge with valid and
// ready both high, on either channel.
// An input passes the lane register, then the output register.
// Throughput: one transaction per cycle while blk_out is not stalled, set
// by the two-stage pipeline (four S-box lanes into a register, then the
// MixColumns merge into the output register).
// Reset clears both stage valid bits; no result is shown after reset and
// the block is ready at once.
// When the receiver stalls, the result stays on blk_out unchanged and one
// more item is still taken into the lane stage; after that blk_in.ready
// drops until the output moves.
// depends on aesrnd_pkg, aesrnd_if, aesrnd_lane, aesrnd_merge
module aes_round_without_key_add_unit
	import aesrnd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	aesrnd_in_if.sink    blk_in,
	aesrnd_out_if.source blk_out
);

	logic         valid_s1;
	logic         valid_s2;
	logic         adv_s2;
	pipe_ctl_t    ctl;
	logic [127:0] state_in;
	column_t      lane_in [NumCols];
	column_t      lane_out [NumCols];

	// handshake and stage enables
	assign adv_s2      = !valid_s2 || blk_out.ready;
	assign blk_in.ready = !valid_s1 || adv_s2;
	assign ctl.load_s1 = blk_in.valid && blk_in.ready;
	assign ctl.load_s2 = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ctl.load_s1) begin
				valid_s1 <= 1'b1;
			end else if (ctl.load_s2) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.load_s2) begin
				valid_s2 <= 1'b1;
			end else if (blk_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// ShiftRows as wiring: lane c row r takes byte 4((c+r) mod 4)+r
	assign state_in = {blk_in.state_hi, blk_in.state_lo};

	always_comb begin
		for (int c = 0; c < NumCols; c++) begin
			for (int r = 0; r < NumRows; r++) begin
				lane_in[c][r] = state_in[127 - 8*(4*((c + r) % NumCols) + r) -: 8];
			end
		end
	end

	// one S-box lane per column
	for (genvar c = 0; c < NumCols; c++) begin : g_lane
		aesrnd_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.col_in  (lane_in[c]),
			.col_out (lane_out[c])
		);
	end

	aesrnd_merge u_merge (
		.clk       (clk),
		.ctl       (ctl),
		.cols      (lane_out),
		.result_hi (blk_out.result_hi),
		.result_lo (blk_out.result_lo)
	);

	assign blk_out.valid = valid_s2;

endmodule

// ----- design/aesrnd_lane.sv -----
// one column lane: S-box on four bytes already placed by ShiftRows
// depends on aesrnd_pkg
module aesrnd_lane
	import aesrnd_pkg::*;
(
	input  logic      clk,
	input  pipe_ctl_t ctl,
	input  column_t   col_in,
	output column_t   col_out
);

	column_t sub_s1;

	// substitute every byte and hold it for the mixing stage
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			for (int r = 0; r < NumRows; r++) begin
				sub_s1[r] <= SBOX[col_in[r]];
			end
		end
	end

	assign col_out = sub_s1;

endmodule

// ----- design/aesrnd_merge.sv -----
// merging stage: MixColumns over the lane outputs, packing, output register
// depends on aesrnd_pkg
module aesrnd_merge
	import aesrnd_pkg::*;
(
	input  logic        clk,
	input  pipe_ctl_t   ctl,
	input  column_t     cols [NumCols],
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);

	column_t       mixed [NumCols];
	logic [127:0]  packed_res;
	logic [127:0]  result_s2;

	// circulant (02 03 01 01) per column
	always_comb begin
		for (int c = 0; c < NumCols; c++) begin
			mixed[c][0] = gf_double(cols[c][0]) ^ gf_double(cols[c][1]) ^ cols[c][1]
				^ cols[c][2] ^ cols[c][3];
			mixed[c][1] = cols[c][0] ^ gf_double(cols[c][1]) ^ gf_double(cols[c][2])
				^ cols[c][2] ^ cols[c][3];
			mixed[c][2] = cols[c][0] ^ cols[c][1] ^ gf_double(cols[c][2])
				^ gf_double(cols[c][3]) ^ cols[c][3];
			mixed[c][3] = gf_double(cols[c][0]) ^ cols[c][0] ^ cols[c][1]
				^ cols[c][2] ^ gf_double(cols[c][3]);
		end
	end

	// byte 4c+r lands at bits 127-8(4c+r) downward
	always_comb begin
		for (int c = 0; c < NumCols; c++) begin
			for (int r = 0; r < NumRows; r++) begin
				packed_res[127 - 8*(4*c + r) -: 8] = mixed[c][r];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			result_s2 <= packed_res;
		end
	end

	assign result_hi = result_s2[127:64];
	assign result_lo = result_s2[63:0];

endmodule

// ----- design/aesrnd_checker.sv -----
// port-level checker for the AES round block, bound to the top level
// depends on assert_macros.svh and aes_round_without_key_add_unit
`include "assert_macros.svh"

module aesrnd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result_hi,
	input logic [63:0] result_lo
);

	logic [1:0] occ_q;
	logic       in_xact;
	logic       out_xact;

	assign in_xact  = in_valid && in_ready;
	assign out_xact = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 2'd0;
		end else if (in_xact && !out_xact) begin
			occ_q <= occ_q + 2'd1;
		end else if (out_xact && !in_xact) begin
			occ_q <= occ_q - 2'd1;
		end
	end

	`AR_ASSERT(a_hold_valid, out_valid && !out_ready |=> out_valid)
	`AR_ASSERT(a_hold_data, out_valid && !out_ready |=> $stable(result_hi) && $stable(result_lo))
	`AR_NEVER(a_no_phantom, out_valid && occ_q == 2'd0)
	`AR_ASSERT(a_ready_room, occ_q != 2'd2 |-> in_ready)

endmodule

bind aes_round_without_key_add_unit aesrnd_checker u_aesrnd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (blk_in.valid),
	.in_ready  (blk_in.ready),
	.out_valid (blk_out.valid),
	.out_ready (blk_out.ready),
	.result_hi (blk_out.result_hi),
	.result_lo (blk_out.result_lo)
);

// ----- tb/sv/aes_round_without_key_add_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench for aes_round_without_key_add_unit: SubBytes, ShiftRows, MixColumns
// depends on aesrnd_pkg, aesrnd_if and the unit itself; builds its own S-box for prediction

module aes_round_without_key_add_unit_tb;

	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned HoldOff = 300;
	localparam logic [7:0] GfPoly = 8'h1B;
	localparam logic [7:0] AffineConst = 8'h63;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} round_t;

	logic clk;
	logic arst_n;

	aesrnd_in_if  in_ch ();
	aesrnd_out_if out_ch ();

	aes_round_without_key_add_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (in_ch.sink),
		.blk_out (out_ch.source)
	);

	logic [7:0] sub_table [256];
	round_t     pending_rounds [$];
	round_t     got_round;
	int         err_count = 0;
	int         idle_cycles = 0;
	int         hold_cycles = 0;
	bit         src_idle_en = 1'b0;
	bit         snk_idle_en = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gf(2^8) helpers for the predictor
	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
	endfunction

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ x;
			end
			x = xtime(x);
		end
		return p;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] b, input int k);
		logic [15:0] w;
		w = {b, b} << k;
		return w[15:8];
	endfunction

	// s-box from the field inverse (x^254) followed by the affine map
	task automatic build_sub_table();
		logic [7:0] inv;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			for (int k = 0; k < 254; k++) begin
				inv = gf_times(inv, x[7:0]);
			end
			sub_table[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
				^ rotl8(inv, 4) ^ AffineConst;
		end
	endtask

	// one round without key addition on a packed state
	function automatic void aes_round_calc(input logic [63:0] hi, input logic [63:0] lo,
		output logic [63:0] res_hi, output logic [63:0] res_lo);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] m [16];
		logic [7:0] a0, a1, a2, a3;
		for (int i = 0; i < 8; i++) begin
			s[i] = hi[63 - 8*i -: 8];
			s[8 + i] = lo[63 - 8*i -: 8];
		end
		// byte substitution with row rotation
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c + r] = sub_table[s[4*((c + r) % 4) + r]];
			end
		end
		// column mix with the (02 03 01 01) circulant
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c + 1];
			a2 = t[4*c + 2];
			a3 = t[4*c + 3];
			m[4*c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			m[4*c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			m[4*c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			m[4*c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end
		res_hi = '0;
		res_lo = '0;
		for (int i = 0; i < 8; i++) begin
			res_hi = (res_hi << 8) | 64'(m[i]);
			res_lo = (res_lo << 8) | 64'(m[8 + i]);
		end
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// random half state, sometimes built from corner bytes
	function automatic logic [63:0] rand_half();
		logic [63:0] v;
		logic [7:0]  b;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) begin
			for (int i = 0; i < 8; i++) begin
				case ($urandom_range(0, 4))
					0: b = 8'h00;
					1: b = 8'hFF;
					2: b = 8'h80;
					3: b = 8'h7F;
					default: b = 8'($urandom);
				endcase
				v[63 - 8*i -: 8] = b;
			end
		end
		return v;
	endfunction

	// drive one state and record its expected round output on acceptance
	task automatic send_state(input logic [63:0] hi, input logic [63:0] lo);
		int     gap;
		round_t exp_r;
		gap = src_idle_en ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.state_hi <= hi;
		in_ch.state_lo <= lo;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		aes_round_calc(hi, lo, exp_r.hi, exp_r.lo);
		pending_rounds.push_back(exp_r);
	endtask

	// sender pauses until every pending round has come out
	task automatic drain_rounds();
		in_ch.valid <= 1'b0;
		while (pending_rounds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		logic [63:0] chk_hi, chk_lo;
		// predictor sanity against the published first-round vector
		aes_round_calc(64'h193DE3BEA0F4E22B, 64'h9AC68D2AE9F84808, chk_hi, chk_lo);
		if (chk_hi !== 64'h046681E5E0CB199A || chk_lo !== 64'h48F8D37A2806264C) begin
			report_mismatch("predictor disagrees with known round vector");
		end
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		send_state(64'h0000000000000000, 64'h0000000000000000);
		send_state(64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
		send_state(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
		send_state(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		send_state(64'h193DE3BEA0F4E22B, 64'h9AC68D2AE9F84808);
		send_state(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
		send_state(64'hF0F1F2F3F4F5F6F7, 64'hF8F9FAFBFCFDFEFF);
		// input bytes all with the top bit set, then all with it clear
		send_state(64'h8080808080808080, 64'h8080808080808080);
		send_state(64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F);
		send_state(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		// bytes that substitute to zero and to one
		send_state(64'h5252525252525252, 64'h5252525252525252);
		send_state(64'h0909090909090909, 64'h0909090909090909);
		// one live byte per column, rows differ
		send_state(64'hFF00000000FF0000, 64'h0000FF00000000FF);
		send_state(64'h00000000FFFFFFFF, 64'hFFFFFFFF00000000);
		drain_rounds();
	endtask

	task automatic test_random_stream();
		// full rate, then each side idling alone, then both
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		repeat (150) send_state(rand_half(), rand_half());
		src_idle_en = 1'b1;
		repeat (150) send_state(rand_half(), rand_half());
		src_idle_en = 1'b0;
		snk_idle_en = 1'b1;
		repeat (150) send_state(rand_half(), rand_half());
		src_idle_en = 1'b1;
		repeat (550) send_state(rand_half(), rand_half());
	endtask

	task automatic test_backpressure();
		// receiver holds off while the sender keeps offering
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		hold_cycles = HoldOff;
		repeat (60) send_state(rand_half(), rand_half());
		drain_rounds();
	endtask

	task automatic test_drain_pause();
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		repeat (4) begin
			repeat (20) send_state(rand_half(), rand_half());
			drain_rounds();
		end
	endtask

	// receiver ready with random stalls and an occasional long hold
	initial begin
		int stall;
		out_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = snk_idle_en ? $urandom_range(0, 11) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_rounds.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h %h",
					out_ch.result_hi, out_ch.result_lo));
			end else begin
				got_round = pending_rounds.pop_front();
				if (out_ch.result_hi !== got_round.hi) begin
					report_mismatch($sformatf("result_hi %h, expected %h",
						out_ch.result_hi, got_round.hi));
				end
				if (out_ch.result_lo !== got_round.lo) begin
					report_mismatch($sformatf("result_lo %h, expected %h",
						out_ch.result_lo, got_round.lo));
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IdleLimit) begin
				$display("timeout: no transaction for %0d cycles", IdleLimit);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// test sequence
	initial begin
		arst_n         <= 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.state_hi <= '0;
		in_ch.state_lo <= '0;
		build_sub_table();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		test_backpressure();
		test_drain_pause();
		in_ch.valid <= 1'b0;
		while (pending_rounds.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
